>>> rtl/core/smoothed_fractional_predelay_defines.svh
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_FRACTIONAL_PREDELAY_DEFINES_SVH
`define SMOOTHED_FRACTIONAL_PREDELAY_DEFINES_SVH

// Same-cycle implication.
`define SPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: package
// Fixed widths, register indexes, controller states and shared structs.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Delay values are unsigned fixed point held in 31 bits.
  localparam int DELAY_W = 31;

  // Smoothing coefficient, unsigned Q1.16.
  localparam int COEFF_W    = 17;
  localparam int COEFF_FRAC = 16;
  localparam logic [COEFF_W-1:0] COEFF_ONE   = 17'd65536;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 17'd272;

  // Product of coefficient and delay difference.
  localparam int PROD_W = COEFF_W + DELAY_W;
  localparam logic [PROD_W-1:0] COEFF_HALF = PROD_W'(32768);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DELAY_W;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEFF = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROD,
    ST_ROUND,
    ST_UPDATE,
    ST_ADDR,
    ST_WRAP,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  // Strobes from the controller to the interpolator.
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } interp_ctl_t;

endpackage

>>> rtl/core/spd_store.sv
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: sample store
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module spd_store #(
  parameter int DEPTH       = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [SAMPLE_BITS-1:0]   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [SAMPLE_BITS-1:0]   rd_data_a,
  output logic [SAMPLE_BITS-1:0]   rd_data_b
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> rtl/core/spd_interp.sv
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: linear interpolator
// Two weighted products, then a rounded floor shift and saturation.
// ----------------------------------------------------------------------------
module spd_interp #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  spd_pkg::interp_ctl_t          ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample_a,
  input  logic signed [SAMPLE_BITS-1:0] sample_b,
  input  logic [FRAC_BITS-1:0]          frac,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int MW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int SW = MW + 1;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  logic [FRAC_BITS:0]      one_minus;
  logic signed [MW-1:0]    prod_a;
  logic signed [MW-1:0]    prod_b;
  logic signed [SW-1:0]    acc;
  logic signed [SW-1:0]    floored;

  assign one_minus = ONE - {1'b0, frac};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_a <= sample_a * $signed({1'b0, one_minus});
      prod_b <= sample_b * $signed({2'b00, frac});
    end
  end

  // Arithmetic shift gives the floor of the rounded sum.
  always_comb begin
    acc     = SW'(prod_a) + SW'(prod_b) + HALF;
    floored = acc >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      if (floored > SMAX) begin
        result <= SMAX[SAMPLE_BITS-1:0];
      end else if (floored < SMIN) begin
        result <= SMIN[SAMPLE_BITS-1:0];
      end else begin
        result <= floored[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

>>> rtl/core/smoothed_fractional_predelay.sv
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay
// Circular sample store with a one-pole smoothed fractional read delay and
// linear interpolation between neighboring stored samples.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  --------------------------------------------------
//   s_axis   in         tdata: sample_in (signed); tuser: block_first
//   m_axis   out        tdata: sample_out (signed, rounded, saturated)
//   cfg      in         index 0 target_delay (Q.FRAC_BITS), 1 smooth_coeff
//
// One beat is handled at a time by a sequencer around a single store with
// one write port and two read ports. A delayed beat runs the serial chain of
// smoothing multiply, pointer arithmetic, store read and interpolation as the
// steps check, product, round, update, address, wrap, read, multiply, sum and
// done, where its output register is loaded; the next beat can be taken once
// the sequencer is back in idle. A pass-through beat goes from check straight
// to done. Reset is synchronous: no store sweep is needed, because a
// written-entry mark (pointer plus a wrapped flag) makes never-written entries
// read as zero. A new input beat is taken while a finished result still waits
// in the output register; the sequencer only stalls at the end of a beat when
// that register is still full and the output side is not ready.
//
module smoothed_fractional_predelay #(
  parameter int DEPTH       = 32768,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [SAMPLE_BITS-1:0] sample_in, upper bits are byte padding
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [0] block_first
  input  logic [0:0]                       s_axis_tuser,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [SAMPLE_BITS-1:0] sample_out, upper bits are zero
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,

  input  logic                             cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = spd_pkg::DELAY_W;
  // Wide enough for pointer arithmetic, the target limit and a sign bit.
  localparam int XW     = ((AW + FRAC_BITS) > DW ? (AW + FRAC_BITS) : DW) + 2;

  localparam logic [XW-1:0] TOTAL_X   = XW'(DEPTH) << FRAC_BITS;
  localparam logic [XW-1:0] MAX_DLY_X = XW'(DEPTH - 2) << FRAC_BITS;
  localparam logic [DW-1:0] HALF_SAMP = DW'(1) << (FRAC_BITS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Control state.
  spd_pkg::state_t               state;
  spd_pkg::state_t               state_next;
  logic [DW-1:0]                 target;
  logic [spd_pkg::COEFF_W-1:0]   coeff;
  logic [DW-1:0]                 smoothed;
  logic [AW-1:0]                 wr_ptr;
  logic                          wrapped;
  logic                          pass_blk;
  logic                          out_valid;

  // Beat payload through the sequence.
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          first_q;
  logic [DW-1:0]                 diff_q;
  logic                          up_q;
  logic [spd_pkg::PROD_W-1:0]    prod_q;
  logic [DW-1:0]                 step_q;
  logic [XW-1:0]                 rp_q;
  logic [AW-1:0]                 idx_q;
  logic [FRAC_BITS-1:0]          frac_q;
  logic                          valid_a_q;
  logic                          valid_b_q;
  logic [SAMPLE_BITS-1:0]        out_sample;

  // Sequencer outputs.
  logic                          in_take;
  logic                          store_wr;
  logic                          store_rd;
  logic                          out_load;
  spd_pkg::interp_ctl_t          ictl;

  // Datapath nets.
  logic                          pass_now;
  logic [XW-1:0]                 cfg_x;
  logic [spd_pkg::PROD_W-1:0]    rounded;
  logic [XW-1:0]                 rp_wrapped;
  logic [AW-1:0]                 nxt_idx;
  logic [SAMPLE_BITS-1:0]        rd_a;
  logic [SAMPLE_BITS-1:0]        rd_b;
  logic signed [SAMPLE_BITS-1:0] interp_a;
  logic signed [SAMPLE_BITS-1:0] interp_b;
  logic signed [SAMPLE_BITS-1:0] interp_res;

  assign s_axis_tready = (state == spd_pkg::ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_sample);

  // The pass-through decision is made only on the first beat of a block and
  // then sticks until the next block start.
  assign pass_now = first_q ? ((target == '0) && (smoothed <= HALF_SAMP)) : pass_blk;

  assign cfg_x      = XW'(cfg_data);
  assign rounded    = prod_q + spd_pkg::COEFF_HALF;
  assign rp_wrapped = rp_q[XW-1] ? (rp_q + TOTAL_X) : rp_q;
  assign nxt_idx    = (idx_q == LAST_ADDR) ? '0 : (idx_q + AW'(1));

  // Entries never written since reset read as zero.
  assign interp_a = valid_a_q ? $signed(rd_a) : '0;
  assign interp_b = valid_b_q ? $signed(rd_b) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    store_wr   = 1'b0;
    store_rd   = 1'b0;
    out_load   = 1'b0;
    ictl       = '0;
    case (state)
      spd_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = spd_pkg::ST_CHECK;
        end
      end
      spd_pkg::ST_CHECK: begin
        if (pass_now) begin
          state_next = spd_pkg::ST_DONE;
        end else begin
          store_wr   = 1'b1;
          state_next = spd_pkg::ST_PROD;
        end
      end
      spd_pkg::ST_PROD:   state_next = spd_pkg::ST_ROUND;
      spd_pkg::ST_ROUND:  state_next = spd_pkg::ST_UPDATE;
      spd_pkg::ST_UPDATE: state_next = spd_pkg::ST_ADDR;
      spd_pkg::ST_ADDR:   state_next = spd_pkg::ST_WRAP;
      spd_pkg::ST_WRAP:   state_next = spd_pkg::ST_READ;
      spd_pkg::ST_READ: begin
        store_rd   = 1'b1;
        state_next = spd_pkg::ST_MUL;
      end
      spd_pkg::ST_MUL: begin
        ictl.mul_en = 1'b1;
        state_next  = spd_pkg::ST_SUM;
      end
      spd_pkg::ST_SUM: begin
        ictl.sum_en = 1'b1;
        state_next  = spd_pkg::ST_DONE;
      end
      spd_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = spd_pkg::ST_IDLE;
        end
      end
      default: state_next = spd_pkg::ST_IDLE;
    endcase
  end

  // Registers that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      coeff     <= spd_pkg::COEFF_RESET;
      smoothed  <= '0;
      wr_ptr    <= '0;
      wrapped   <= 1'b0;
      pass_blk  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Both registers are kept already saturated to their usable range.
      if (cfg_we && (cfg_index == spd_pkg::REG_TARGET_DELAY)) begin
        target <= (cfg_x > MAX_DLY_X) ? MAX_DLY_X[DW-1:0] : cfg_data;
      end
      if (cfg_we && (cfg_index == spd_pkg::REG_SMOOTH_COEFF)) begin
        coeff <= (cfg_data[spd_pkg::COEFF_W-1:0] > spd_pkg::COEFF_ONE) ?
                 spd_pkg::COEFF_ONE : cfg_data[spd_pkg::COEFF_W-1:0];
      end

      if (state == spd_pkg::ST_CHECK) begin
        pass_blk <= pass_now;
        if (first_q && pass_now) begin
          smoothed <= '0;
        end
      end

      // The one-pole step never overshoots, so the sum stays in range.
      if (state == spd_pkg::ST_UPDATE) begin
        smoothed <= up_q ? (smoothed + step_q) : (smoothed - step_q);
      end

      // The pointer moves only after the read mark has been taken.
      if (state == spd_pkg::ST_READ) begin
        wr_ptr  <= (wr_ptr == LAST_ADDR) ? '0 : (wr_ptr + AW'(1));
        wrapped <= wrapped || (wr_ptr == LAST_ADDR);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Beat payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_q <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
      first_q  <= s_axis_tuser[0];
    end
    if (state == spd_pkg::ST_CHECK) begin
      up_q   <= (target >= smoothed);
      diff_q <= (target >= smoothed) ? (target - smoothed) : (smoothed - target);
    end
    if (state == spd_pkg::ST_PROD) begin
      prod_q <= spd_pkg::PROD_W'(coeff) * spd_pkg::PROD_W'(diff_q);
    end
    if (state == spd_pkg::ST_ROUND) begin
      step_q <= rounded[spd_pkg::COEFF_FRAC +: DW];
    end
    // Read position before wrap: write address minus delay, may go negative.
    if (state == spd_pkg::ST_ADDR) begin
      rp_q <= (XW'(wr_ptr) << FRAC_BITS) - XW'(smoothed);
    end
    if (state == spd_pkg::ST_WRAP) begin
      idx_q  <= rp_wrapped[FRAC_BITS +: AW];
      frac_q <= rp_wrapped[FRAC_BITS-1:0];
    end
    // The current sample sits at wr_ptr, so an entry at or below it is live.
    if (state == spd_pkg::ST_READ) begin
      valid_a_q <= wrapped || (idx_q <= wr_ptr);
      valid_b_q <= wrapped || (nxt_idx <= wr_ptr);
    end
    if (out_load) begin
      out_sample <= pass_blk ? sample_q : interp_res;
    end
  end

  // The write lands in the check step, ahead of the reads in the read step,
  // so the store never sees a read and a write of one entry together.
  spd_store #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (wr_ptr),
    .wr_data   (sample_q),
    .rd_en     (store_rd),
    .rd_addr_a (idx_q),
    .rd_addr_b (nxt_idx),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  spd_interp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .ctl      (ictl),
    .sample_a (interp_a),
    .sample_b (interp_b),
    .frac     (frac_q),
    .result   (interp_res)
  );

endmodule

>>> rtl/core/spd_checker.sv
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "smoothed_fractional_predelay_defines.svh"

module spd_checker #(
  parameter int DATA_W = 24
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata
);

  // A waiting result keeps its value until it is taken.
  `SPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

  // The block works on one beat at a time, so it closes right after a take.
  `SPD_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a beat is in progress")

  // Nothing is offered on the output right after reset.
  `SPD_ASSERT_NOW(a_reset_quiet, $past(rst), !m_axis_tvalid, "output valid straight after reset")

endmodule

bind smoothed_fractional_predelay spd_checker #(
  .DATA_W (DATA_W)
) u_spd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/predelay_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: bench predictor and scoreboard
// Tracks the sample history, the smoothed delay and the pass-through decision
// of the block, and compares each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
package predelay_check_pkg;

  localparam int DEPTH       = 32768;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int PTR_W       = $clog2(DEPTH);

  localparam longint unsigned MAX_DELAY = longint'(DEPTH - 2) << FRAC_BITS;
  localparam longint unsigned RING_SPAN = longint'(DEPTH) << FRAC_BITS;
  localparam longint unsigned HALF_SAMPLE = longint'(1) << (FRAC_BITS - 1);
  localparam longint          ONE_Q  = longint'(1) << FRAC_BITS;
  localparam longint          SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint          SAT_LO = -SAT_HI - 1;

  class predelay_predictor;
    bit signed [SAMPLE_BITS-1:0] history [DEPTH];
    bit [PTR_W-1:0]               wr_ptr;
    bit [spd_pkg::DELAY_W-1:0]    smooth_dly;
    bit [spd_pkg::DELAY_W-1:0]    target;
    bit [spd_pkg::COEFF_W-1:0]    coeff;
    bit                           bypass;
    logic [SAMPLE_BITS-1:0]       pending_outputs [$];
    int                           mismatches;

    function new();
      coeff = spd_pkg::COEFF_RESET;
    endfunction

    function void write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx,
                            logic [spd_pkg::CFG_DATA_W-1:0] data);
      if (idx == spd_pkg::REG_TARGET_DELAY) begin
        target = data;
      end else begin
        coeff = data[spd_pkg::COEFF_W-1:0];
      end
    endfunction

    // Works out the output sample caused by one input beat.
    function void accept_sample(logic [SAMPLE_BITS-1:0] value, logic first);
      longint unsigned tgt, c, d, step, sd, rp;
      longint          a, b, f, acc;
      int unsigned     idx, nxt;
      tgt = (target > MAX_DELAY) ? MAX_DELAY : 64'(target);
      c   = 64'((coeff > spd_pkg::COEFF_ONE) ? spd_pkg::COEFF_ONE : coeff);
      if (first) begin
        bypass = (tgt == 0) && (smooth_dly <= HALF_SAMPLE);
        if (bypass) smooth_dly = '0;
      end
      if (bypass) begin
        pending_outputs.push_back(value);
        return;
      end
      history[wr_ptr] = value;
      sd = 64'(smooth_dly);
      if (tgt >= sd) begin
        d    = tgt - sd;
        step = (c * d + 32768) >> 16;
        sd   = sd + step;
      end else begin
        d    = sd - tgt;
        step = (c * d + 32768) >> 16;
        sd   = sd - step;
      end
      smooth_dly = sd[spd_pkg::DELAY_W-1:0];
      rp = 64'(wr_ptr);
      rp = (rp << FRAC_BITS) + RING_SPAN - sd;
      while (rp >= RING_SPAN) rp = rp - RING_SPAN;
      idx = 32'(rp >> FRAC_BITS);
      nxt = (idx + 1) % DEPTH;
      f   = longint'(rp & (ONE_Q - 1));
      a   = longint'(history[idx]);
      b   = longint'(history[nxt]);
      acc = a * (ONE_Q - f) + b * f + (ONE_Q >>> 1);
      acc = acc >>> FRAC_BITS;
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      pending_outputs.push_back(acc[SAMPLE_BITS-1:0]);
      wr_ptr = wr_ptr + 1'b1;
    endfunction

    function void compare_sample(logic [SAMPLE_BITS-1:0] got);
      logic [SAMPLE_BITS-1:0] want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected sample_out beat, expected none, got %06h", $time, got);
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        $display("%0t: sample_out mismatch, expected %06h, got %06h", $time, want, got);
        mismatches++;
      end
    endfunction
  endclass

endpackage

>>> bench/tb_smoothed_fractional_predelay.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Smoothed fractional pre-delay: top-level testbench
// Drives sample beats with block-start marks, reprograms the target delay and
// smoothing coefficient between phases, and checks every output beat against
// a cycle-free predictor under several input and output idling patterns.
// ----------------------------------------------------------------------------
module tb_smoothed_fractional_predelay;
  import predelay_check_pkg::*;

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // Even with 78 percent idling on one side the longest quiet stretch stays
  // far below this limit.
  localparam int QUIET_LIMIT = 4000;

  // Cycles left to pass after the last expected beat before a register is
  // touched, and again at the very end.
  localparam int SETTLE_CYCLES = 16;

  // Beats per random run of host blocks.
  localparam int RUN_BEATS = 56;

  localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [spd_pkg::DELAY_W-1:0] TOP_TARGET = spd_pkg::DELAY_W'(MAX_DELAY);

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [23:0] sample_in
  logic [TDATA_W-1:0]              s_axis_tdata  = '0;
  // [0] block_first
  logic [0:0]                      s_axis_tuser  = '0;

  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [23:0] sample_out
  logic [TDATA_W-1:0]              m_axis_tdata;

  logic                            cfg_we    = 1'b0;
  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Idling odds in percent, changed per phase by the main sequence.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int quiet_cycles  = 0;

  predelay_predictor predictor;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  smoothed_fractional_predelay #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Output side: ready is redrawn on every falling edge, and a beat is taken
  // and checked on the rising edge where valid and ready are both high.
  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      predictor.compare_sample(m_axis_tdata[SAMPLE_BITS-1:0]);
    end
  end

  // Watchdog: any beat on either side restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one sample beat, with random idle cycles ahead of it, and holds
  // it until the block takes it. Valid stays high into the next beat when no
  // idle cycle is drawn, so it drops only for the idle cycles that are drawn.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic first);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(value);
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predictor.accept_sample(value, first);
  endtask

  // Drops valid, waits until every predicted beat has come out, then lets
  // the block settle.
  task automatic drain_outputs();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (predictor.pending_outputs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic program_delay(input logic [spd_pkg::DELAY_W-1:0] tgt,
                               input logic [spd_pkg::COEFF_W-1:0] coeff);
    drain_outputs();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= spd_pkg::REG_TARGET_DELAY;
    cfg_data  <= tgt;
    @(negedge clk);
    cfg_index <= spd_pkg::REG_SMOOTH_COEFF;
    cfg_data  <= spd_pkg::CFG_DATA_W'(coeff);
    @(negedge clk);
    cfg_we    <= 1'b0;
    predictor.write_reg(spd_pkg::REG_TARGET_DELAY, tgt);
    predictor.write_reg(spd_pkg::REG_SMOOTH_COEFF, spd_pkg::CFG_DATA_W'(coeff));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Zero targets are common so that pass-through blocks show up; targets
  // above the saturation point and at it are drawn as well.
  function automatic logic [spd_pkg::DELAY_W-1:0] pick_target();
    case ($urandom_range(0, 7))
      0, 1:    return '0;
      2:       return TOP_TARGET;
      3:       return spd_pkg::DELAY_W'($urandom_range(32'h7FFF_FFFF, 32'(MAX_DELAY + 1)));
      4:       return spd_pkg::DELAY_W'($urandom_range(1, 32'h0000_FFFF));
      default: return spd_pkg::DELAY_W'($urandom_range(1, 64 << FRAC_BITS));
    endcase
  endfunction

  function automatic logic [spd_pkg::COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return spd_pkg::COEFF_RESET;
      2:       return spd_pkg::COEFF_ONE;
      3:       return spd_pkg::COEFF_W'($urandom_range(32'h0001_FFFF, 32'h0001_0001));
      default: return spd_pkg::COEFF_W'($urandom_range(1, 32'h0000_FFFF));
    endcase
  endfunction

  // Host blocks of random length, each opened by a marked beat; one beat in
  // twenty has its mark flipped to break the block structure.
  task automatic send_blocks(input int count);
    int   left;
    int   blen;
    logic first;
    left = count;
    while (left > 0) begin
      blen = $urandom_range(1, 48);
      for (int k = 0; k < blen && left > 0; k++) begin
        first = (k == 0);
        if ($urandom_range(0, 19) == 0) first = ~first;
        send_sample(random_sample(), first);
        left--;
      end
    end
  endtask

  initial begin
    predictor = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Before any block start the block delays normally; with the reset
    // settings the delay is zero, so each beat returns the sample just
    // written.
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(24'h123456, 1'b0);

    // A marked beat with a zero target and zero smoothed delay opens a
    // pass-through block.
    send_sample(24'h7ABCDE, 1'b1);
    send_sample(FULL_NEG, 1'b0);
    send_sample(FULL_POS, 1'b0);

    // A unit coefficient moves the smoothed delay onto the target in one step.
    // Half-sample interpolation between the extremes checks the rounding.
    program_delay(31'h0001_8000, spd_pkg::COEFF_ONE);
    send_sample(FULL_POS, 1'b1);
    send_sample(FULL_NEG, 1'b0);
    send_sample(FULL_POS, 1'b0);
    send_sample(FULL_NEG, 1'b0);
    send_sample(24'h000005, 1'b0);

    // Smoothed delay of exactly half a sample still allows pass-through.
    program_delay(31'h0000_8000, spd_pkg::COEFF_ONE);
    send_sample(24'h000064, 1'b1);
    program_delay('0, spd_pkg::COEFF_ONE);
    send_sample(24'h00012C, 1'b1);

    // Just above half a sample it does not; the delay then falls to zero,
    // and the next marked beat passes through.
    program_delay(31'h0000_8001, spd_pkg::COEFF_ONE);
    send_sample(24'h000190, 1'b1);
    program_delay('0, spd_pkg::COEFF_ONE);
    send_sample(24'h000258, 1'b1);
    send_sample(24'h0002BC, 1'b1);

    // Register values beyond the saturation points of both registers.
    program_delay(31'h7FFF_FFFF, 17'h1_FFFF);
    send_sample(24'h000001, 1'b1);
    send_sample(24'h000002, 1'b0);

    // A zero coefficient freezes the smoothed delay.
    program_delay(31'h0003_0000, '0);
    send_sample(24'h000003, 1'b1);

    // The reset coefficient glides slowly down from the longest delay.
    program_delay(31'h0005_0000, spd_pkg::COEFF_RESET);
    send_sample(FULL_POS, 1'b1);
    send_sample(FULL_NEG, 1'b0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 78; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 78; end
        default: begin src_idle_pct = 18; snk_stall_pct = 18; end
      endcase
      repeat (2) begin
        program_delay(pick_target(), pick_coeff());
        send_blocks(RUN_BEATS);
      end
    end

    // Read far behind the write pointer, so that the read position wraps
    // around the end of the store onto entries that were never written.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    program_delay(31'h7D00_8000, spd_pkg::COEFF_ONE);
    send_blocks(40);

    drain_outputs();
    if (predictor.mismatches == 0 && predictor.pending_outputs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
